// ----- rtl/mvavg_pkg.sv -----
// mvavg_pkg: shared types and constants for the moving average filter
// no dependencies; imported by the divider, the top level, the checker and the test

package mvavg_pkg;

   localparam int SampleW = 8;   // sample and average width
   localparam int CfgW    = 5;   // window register write width

   localparam logic [CfgW-1:0] WindowReset = 5'd10;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/mvavg_ram.sv -----
// mvavg_ram: generic single-clock ram, one write port, one registered read port
// no dependencies

module mvavg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mvavg_div.sv -----
// mvavg_div: restoring divider, one quotient bit per cycle
// depends on mvavg_pkg for the status struct

module mvavg_div #(
   parameter int NUM_W = 12,
   parameter int DEN_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              dividend,
   input  logic [DEN_W-1:0]              divisor,
   output mvavg_pkg::div_status_type     status,
   output logic [NUM_W-1:0]              quotient
);

   import mvavg_pkg::*;

   localparam int CntW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/moving_average_filter_core.sv -----
// moving_average_filter_core: top level of the moving average filter
// depends on mvavg_pkg, mvavg_ram and mvavg_div
//
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_sample[7:0]
// rsp       out  rsp_valid/rsp_stall  rsp_average[7:0]
// csr       in   csr_wr_en            csr_wr_data[4:0] (window size)
//
// one word at a time: the accept state, a ring read and sum update state, the
// divide state that waits while the divider forms all SumW quotient bits (12 at
// the default) and raises done, then the move into the output register, which
// waits while an earlier average is still held; the next word is taken after that
// synchronous reset sets the window to 10 and empties the ring, sum and slot
// a new word is taken while a finished average still waits on rsp_stall

module moving_average_filter_core #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mvavg_pkg::SampleW-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mvavg_pkg::SampleW-1:0] rsp_average,
   input  logic                         csr_wr_en,
   input  logic [mvavg_pkg::CfgW-1:0]    csr_wr_data
);

   import mvavg_pkg::*;

   // widths that follow from the window depth
   localparam int SlotW = $clog2(MAX_WINDOW);
   localparam int WinW  = (MAX_WINDOW >= 31) ? CfgW : $clog2(MAX_WINDOW + 1);
   localparam int SumW  = $clog2(255 * MAX_WINDOW + 1);
   localparam logic [8:0] MaxWin = 9'(MAX_WINDOW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [WinW-1:0]      window_ff, window_in;
   logic [SlotW-1:0]     slot_ff, slot_in;
   logic [SumW-1:0]      sum_ff, sum_in;
   logic [MAX_WINDOW-1:0] vld_ff, vld_in;      // ring entries written since clear
   logic [SampleW-1:0]   sample_ff, sample_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SampleW-1:0]   average_ff, average_in;

   logic                 accept;
   logic                 rsp_take;
   logic [SampleW-1:0]   ram_rd_data;
   logic [SampleW-1:0]   old_sample;
   logic                 ram_wr_en;
   logic                 div_start;
   div_status_type       div_status;
   logic [SumW-1:0]      div_quotient;
   logic [8:0]           cfg_value;
   logic [8:0]           slot_next;
   logic [SlotW-1:0]     slot_cur;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // stale slot after a shrink cannot happen (config clears it), but wrap anyway
   assign slot_cur = (9'(slot_ff) >= 9'(window_ff)) ? '0 : slot_ff;

   // entries never written since the last clear read as zero
   assign old_sample = vld_ff[slot_cur] ? ram_rd_data : '0;

   assign cfg_value = 9'(csr_wr_data);
   assign slot_next = 9'(slot_cur) + 9'd1;

   assign ram_wr_en = (state_ff == ST_READ);
   assign div_start = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      vld_in       = vld_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      average_in   = average_ff;

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // ring data for the current slot arrived; update sum and write back
            sum_in = sum_ff - SumW'(old_sample) + SumW'(sample_ff);
            vld_in[slot_cur] = 1'b1;
            slot_in  = (slot_next >= 9'(window_ff)) ? '0 : SlotW'(slot_next);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               average_in   = div_quotient[SampleW-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // window write: user writes only while idle, not enforced here; saturate to 1..MAX_WINDOW and clear the ring
      if (csr_wr_en) begin
         if (cfg_value == 9'd0) begin
            window_in = WinW'(1);
         end else if (cfg_value > MaxWin) begin
            window_in = WinW'(MaxWin);
         end else begin
            window_in = WinW'(cfg_value);
         end
         vld_in  = '0;
         sum_in  = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= (9'(WindowReset) > MaxWin) ? WinW'(MaxWin) : WinW'(WindowReset);
         slot_ff      <= '0;
         sum_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      average_ff <= average_in;
   end

   // busy until the current word is finished and parked in the output register
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = average_ff;

   // sample ring: read issued on accept, written back in the cycle after
   mvavg_ram #(
      .WIDTH (SampleW),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_cur),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (slot_cur),
      .rd_data (ram_rd_data)
   );

   // sum / window, started with the freshly updated sum
   mvavg_div #(
      .NUM_W (SumW),
      .DEN_W (WinW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (window_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // write slot stays inside the window
   assert property (@(posedge clock) disable iff (reset)
      9'(slot_ff) < 9'(window_ff))
      else $error("write slot outside window");

   // window stays within 1..MAX_WINDOW
   assert property (@(posedge clock) disable iff (reset)
      window_ff != '0 && 9'(window_ff) <= MaxWin)
      else $error("window out of range");

   // running sum never exceeds a full window of maximum samples
   assert property (@(posedge clock) disable iff (reset)
      32'(sum_ff) <= 32'(255) * 32'(window_ff))
      else $error("running sum too large");

   // divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIV)
      else $error("divider busy outside divide state");

   // an accepted word always goes to the ring read next
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted word did not start a ring read");

endmodule

// ----- tb/moving_average_filter_checker.sv -----
`timescale 1ns / 100ps
// moving_average_filter_checker: predicts the average for every accepted word and
// checks each word on the result channel against it; depends on mvavg_pkg

module moving_average_filter_checker #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [mvavg_pkg::SampleW-1:0] req_sample,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [mvavg_pkg::SampleW-1:0] rsp_average,
   input  logic                         csr_wr_en,
   input  logic [mvavg_pkg::CfgW-1:0]    csr_wr_data,
   output int                           mismatch_count,
   output int                           averages_pending
);

   import mvavg_pkg::*;

   localparam int SumW = $clog2(255 * MAX_WINDOW + 1);

   logic [SampleW-1:0] sample_history [MAX_WINDOW];
   logic [SumW-1:0]    running_sum;
   int unsigned        next_slot;
   int unsigned        window_len;
   logic [SampleW-1:0] expected_averages [$];

   function automatic int unsigned clamp_window(logic [CfgW-1:0] value);
      if (value == '0) return 1;
      if (int'(value) > MAX_WINDOW) return MAX_WINDOW;
      return 32'(value);
   endfunction

   function automatic void clear_history();
      foreach (sample_history[i]) sample_history[i] = '0;
      running_sum = '0;
      next_slot   = 0;
   endfunction

   function automatic logic [SampleW-1:0] predict_average(logic [SampleW-1:0] sample);
      if (next_slot >= window_len) next_slot = 0;
      running_sum = running_sum - sample_history[next_slot] + sample;
      sample_history[next_slot] = sample;
      next_slot = (next_slot + 1 >= window_len) ? 0 : next_slot + 1;
      return SampleW'(running_sum / window_len);
   endfunction

   always @(posedge clock) begin : monitor
      logic [SampleW-1:0] wanted;
      if (reset) begin
         window_len = clamp_window(WindowReset);
         clear_history();
         expected_averages.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            window_len = clamp_window(csr_wr_data);
            clear_history();
         end
         if (req_valid && !req_stall)
            expected_averages.push_back(predict_average(req_sample));
         if (rsp_valid && !rsp_stall) begin
            if (expected_averages.size() == 0) begin
               $error("average: expected none, actual %0d", rsp_average);
               mismatch_count++;
            end else begin
               wanted = expected_averages.pop_front();
               if (rsp_average !== wanted) begin
                  $error("average: expected %0d, actual %0d", wanted, rsp_average);
                  mismatch_count++;
               end
            end
         end
      end
      averages_pending = expected_averages.size();
   end

endmodule

// ----- tb/moving_average_filter_core_test.sv -----
`timescale 1ns / 100ps
// moving_average_filter_core_test: stimulus and verdict for the moving average filter
// depends on mvavg_pkg, moving_average_filter_core and moving_average_filter_checker

module moving_average_filter_core_test;

   import mvavg_pkg::*;

   localparam int MaxWindow    = 16;
   localparam int QuietLimit   = 4000;  // cycles with no word moving before giving up
   localparam int DrainCycles  = 30;    // more than the word latency, for stray words after the drain
   localparam int SegmentWords = 112;   // 8 segments with runs, about 1320 random words

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [SampleW-1:0] req_sample  = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [SampleW-1:0] rsp_average;
   logic               csr_wr_en   = 1'b0;
   logic [CfgW-1:0]    csr_wr_data = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count;
   int averages_pending;
   int quiet_cycles       = 0;

   // 4 ns period
   always #2 clock = ~clock;

   moving_average_filter_core #(
      .MAX_WINDOW(MaxWindow)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_average(rsp_average),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // the checker watches the same wires and keeps its own copy of the window
   moving_average_filter_checker #(
      .MAX_WINDOW(MaxWindow)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .averages_pending(averages_pending)
   );

   // receiver back-pressure, redrawn every cycle independent of rsp_valid
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // watchdog: any word moving on either channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QuietLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // offer one sample, with random idle cycles in front of it; called and
   // returns at a falling edge, valid stays high so back-to-back words need
   // no drop in between
   task automatic send_sample(input logic [SampleW-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      // payload holds while stalled
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop offering words until every predicted average has come back
   task automatic drain_averages();
      req_valid <= 1'b0;
      while (averages_pending != 0) @(negedge clock);
   endtask

   // single-cycle window register write, only while the block is idle
   task automatic write_window(input logic [CfgW-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [CfgW-1:0]    window_value;
      logic [SampleW-1:0] run_value;
      int                 pick;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default window of 10, low and high samples
      send_sample(8'h00);
      send_sample(8'hFF);
      send_sample(8'h01);

      // window of zero saturates to one, so every word wraps the slot
      drain_averages();
      write_window(5'd0);
      send_sample(8'hFF);
      send_sample(8'h00);
      send_sample(8'hAA);

      // all ones saturates to the widest window; full-scale run fills the
      // sum to its top and wraps the slot once
      drain_averages();
      write_window(5'd31);
      repeat (18) send_sample(8'hFF);

      // random segments, each with its own window and its own idling mode
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0:       window_value = 5'd1;
            1:       window_value = 5'd16;
            2:       window_value = 5'd0;
            3:       window_value = 5'd31;
            4:       window_value = 5'd17;
            5:       window_value = 5'd2;
            6:       window_value = CfgW'($urandom_range(0, 31));
            default: window_value = CfgW'($urandom_range(3, 15));
         endcase
         drain_averages();
         write_window(window_value);

         // no idling, sender idle, receiver stalling, then both
         case (seg % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 84;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 84;
            end
            default: begin
               sender_idle_pct    = 28;
               receiver_stall_pct = 28;
            end
         endcase

         for (int i = 0; i < SegmentWords; i++) begin
            // in segment 2 the sender holds off once mid-segment until the pipe is empty
            if (seg == 2 && i == SegmentWords / 2) drain_averages();
            if ($urandom_range(0, 39) == 0) begin
               // a run longer than any window drives the mean to a rail
               run_value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               repeat (MaxWindow + 4) send_sample(run_value);
            end else begin
               pick = $urandom_range(0, 9);
               if (pick < 2)      send_sample(8'hFF);
               else if (pick < 3) send_sample(8'h00);
               else               send_sample(SampleW'($urandom_range(0, 255)));
            end
         end
      end

      // let the last averages come out, then a little more for stray words
      drain_averages();
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && averages_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
